@@ rtl/fenwick_point_set_range_sum_assert.svh @@
// assertion macros for the checker file
`ifndef FENWICK_POINT_SET_RANGE_SUM_ASSERT_SVH
`define FENWICK_POINT_SET_RANGE_SUM_ASSERT_SVH

// condition implies consequence in the same cycle, ignored during reset
`define FPSRS_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("fenwick tree check failed");

// condition implies consequence in the next cycle, ignored during reset
`define FPSRS_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("fenwick tree check failed");

// condition implies consequence in the next cycle, also checked through reset
`define FPSRS_ASSERT_NEXT_ALWAYS(label, cond, cons) \
  label: assert property (@(posedge clk) (cond) |=> (cons)) \
    else $error("fenwick tree check failed");

`endif

@@ rtl/fpsrs_pkg.sv @@
// shared types and constants of the fenwick tree block
package fpsrs_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int IDX_W           = 10;
  localparam int ACT_W           = 11;
  localparam int VAL_W           = 64;
  localparam int KIND_W          = 2;
  localparam int IN_DATA_W       = 88;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 11'd1024;

  // register indexes
  localparam int REG_ACTIVE = 0;

  // request kinds
  localparam logic [KIND_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] REQ_SET   = 2'd1;
  localparam logic [KIND_W-1:0] REQ_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_DONE,
    ST_ADD_RD,
    ST_ADD_WR
  } state_t;

  // one request as handed from the stream port to the sequencer
  typedef struct packed {
    logic [KIND_W-1:0] req_type;
    logic [IDX_W-1:0]  index_low;
    logic [IDX_W-1:0]  index_high;
    logic [VAL_W-1:0]  operand_value;
  } req_t;

endpackage

@@ rtl/fpsrs_ram.sv @@
// generic single write port, single read port ram with registered read
module fpsrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fpsrs_seq.sv @@
// request sequencer: clearing pass, prefix walks, update walk and result register
module fpsrs_seq #(
  parameter int MAX_ENTRIES = fpsrs_pkg::MAX_ENTRIES_DEF,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [fpsrs_pkg::ACT_W-1:0]  active,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fpsrs_pkg::req_t              req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fpsrs_pkg::VAL_W-1:0]  out_data,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [fpsrs_pkg::VAL_W-1:0]  ram_wdata,
  output logic                         ram_re,
  output logic [AW-1:0]                ram_raddr,
  input  logic [fpsrs_pkg::VAL_W-1:0]  ram_rdata
);
  import fpsrs_pkg::*;

  // tree positions run from 1 and may step past the limit once
  localparam int PW = ((AW > IDX_W) ? AW : IDX_W) + 2;
  localparam logic [PW-1:0] MAX_P   = PW'(MAX_ENTRIES);
  localparam logic [AW-1:0] LAST_AD = AW'(MAX_ENTRIES - 1);

  function automatic logic [PW-1:0] low_bit(input logic [PW-1:0] v);
    return v & (~v + PW'(1));
  endfunction

  state_t            state;
  state_t            state_next;
  logic [AW-1:0]     clr_addr;
  logic [KIND_W-1:0] kind;
  logic [VAL_W-1:0]  val;
  logic [VAL_W-1:0]  delta;
  logic [VAL_W-1:0]  acc;
  logic [PW-1:0]     pos_a;
  logic [PW-1:0]     pos_b;
  logic [PW-1:0]     add_pos;
  logic              pend;
  logic              pend_neg;

  logic [PW-1:0] active_p;
  logic [PW-1:0] lim;
  logic [PW-1:0] low_p;
  logic [PW-1:0] high_p;
  logic [PW-1:0] rd_pos;
  logic [PW-1:0] rd_pm1;
  logic [PW-1:0] wr_pm1;
  logic          accept;
  logic          out_load;

  // active element limit, clamped to the store size
  assign active_p = {{(PW-ACT_W){1'b0}}, active};
  assign lim      = (active_p > MAX_P) ? MAX_P : active_p;
  assign low_p    = {{(PW-IDX_W){1'b0}}, req.index_low};
  assign high_p   = {{(PW-IDX_W){1'b0}}, req.index_high};
  assign accept   = in_valid && in_ready;
  assign out_load = (state == ST_DONE) && (kind == REQ_QUERY) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_AD) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (req.req_type)
            REQ_ADD:           state_next = ST_ADD_RD;
            REQ_SET, REQ_QUERY: state_next = ST_WALK_A;
            default:           state_next = ST_DONE;
          endcase
        end
      end
      ST_WALK_A: begin
        if (pos_a == '0) state_next = ST_WALK_B;
      end
      ST_WALK_B: begin
        if (pos_b == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        case (kind)
          REQ_SET:   state_next = ST_ADD_RD;
          REQ_QUERY: state_next = out_load ? ST_IDLE : ST_DONE;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_ADD_RD: begin
        state_next = (add_pos <= lim) ? ST_ADD_WR : ST_IDLE;
      end
      ST_ADD_WR: state_next = ST_ADD_RD;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = ram_rdata + delta;
    rd_pos    = add_pos;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_WALK_A: begin
        rd_pos = pos_a;
        ram_re = (pos_a != '0) && (pos_a <= MAX_P);
      end
      ST_WALK_B: begin
        rd_pos = pos_b;
        ram_re = (pos_b != '0) && (pos_b <= MAX_P);
      end
      ST_ADD_RD: ram_re = (add_pos <= lim);
      ST_ADD_WR: ram_we = 1'b1;
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      default: ;
    endcase
  end

  // positions map to memory addresses one below
  assign rd_pm1    = rd_pos - PW'(1);
  assign wr_pm1    = add_pos - PW'(1);
  assign ram_raddr = rd_pm1[AW-1:0];
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : wr_pm1[AW-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      pend <= ram_re && ((state == ST_WALK_A) || (state == ST_WALK_B));
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pend_neg <= (state == ST_WALK_B);
    if (accept) begin
      kind    <= req.req_type;
      val     <= req.operand_value;
      delta   <= req.operand_value;
      acc     <= '0;
      pos_a   <= ((req.req_type == REQ_QUERY) ? high_p : low_p) + PW'(1);
      pos_b   <= low_p;
      add_pos <= low_p + PW'(1);
    end else if (pend) begin
      // read data lands in the cycle after its address
      acc <= pend_neg ? (acc - ram_rdata) : (acc + ram_rdata);
    end
    if (state == ST_WALK_A && pos_a != '0) pos_a <= pos_a - low_bit(pos_a);
    if (state == ST_WALK_B && pos_b != '0) pos_b <= pos_b - low_bit(pos_b);
    if (state == ST_DONE && kind == REQ_SET) delta <= val - acc;
    if (state == ST_ADD_WR) add_pos <= add_pos + low_bit(add_pos);
    if (out_load) out_data <= acc;
  end

endmodule

@@ rtl/fenwick_point_set_range_sum.sv @@
// top level of the fenwick tree point set and range sum block
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------
//  apb      | in/out    | active_entries register at byte address 0
//  s_axis   | in        | request: kind, indexes, operand
//  m_axis   | out       | range sum, one per query
//
// after reset a clearing pass writes zero to all MAX_ENTRIES entries, one a
// cycle, and no request is taken until it ends; register writes go on as ever.
// one request at a time; a prefix walk reads one node per set bit of its
// count, and an update walk reads, then writes back, one node per step.
// add: the update walk alone; query: both prefix walks; set: both walks then the update.
// a held result stalls only the next query at its end; the memory port sets the pace.
module fenwick_point_set_range_sum #(
  parameter int MAX_ENTRIES = fpsrs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fpsrs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fpsrs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fpsrs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // index_low [9:0], index_high [19:10], operand_value [83:20], zero pad
  input  logic [fpsrs_pkg::IN_DATA_W-1:0]   s_tdata,
  // req_type [1:0]
  input  logic [fpsrs_pkg::KIND_W-1:0]      s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // range_sum [63:0]
  output logic [fpsrs_pkg::VAL_W-1:0]       m_tdata
);
  import fpsrs_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [ACT_W-1:0] active;
  logic [0:0]       reg_idx;
  logic             cfg_wr;
  req_t             req;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  // register file: one register, word addressed
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == 1'(REG_ACTIVE));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      active <= pwdata[ACT_W-1:0];
    end
  end

  assign prdata = (reg_idx == 1'(REG_ACTIVE)) ?
                  {{(APB_DATA_W-ACT_W){1'b0}}, active} : '0;

  // unpack the request transaction
  assign req.req_type      = s_tuser;
  assign req.index_low     = s_tdata[IDX_W-1:0];
  assign req.index_high    = s_tdata[2*IDX_W-1:IDX_W];
  assign req.operand_value = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

  fpsrs_seq #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .active   (active),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .req      (req),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  // partial sums store, position p at address p-1
  fpsrs_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_ENTRIES)
  ) u_sums (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

@@ rtl/fpsrs_check.sv @@
// port level checker for the fenwick tree block, bound to the top level
`include "fenwick_point_set_range_sum_assert.svh"

module fpsrs_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              psel,
  input logic                              pready,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [fpsrs_pkg::VAL_W-1:0]       m_tdata
);

  // the register port never waits
  `FPSRS_ASSERT_NOW(a_pready_high, psel, pready)

  // a held result keeps its value until taken
  `FPSRS_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one request at a time: an accepted transaction closes the input
  `FPSRS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

  // reset starts the clearing pass and empties the result register
  `FPSRS_ASSERT_NEXT_ALWAYS(a_reset_state, rst, !s_tready && !m_tvalid)

endmodule

bind fenwick_point_set_range_sum fpsrs_check u_check (.*);
